// File: rtl/core/btt_pkg.sv
// Shared types, codes and helpers for the broadcast transaction table.
// No dependencies; every other file of the block takes names from here.
`timescale 1ns / 1ps

package btt_pkg;

    // Table geometry
    localparam int ENTRIES   = 3;
    localparam int NEIGHBORS = 16;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int MASK_W = 16;

    localparam logic [MASK_W-1:0] NB_MASK = MASK_W'((33'd1 << NEIGHBORS) - 33'd1);

    // Input function codes
    localparam logic [1:0] FUNC_NEW    = 2'd0;
    localparam logic [1:0] FUNC_JITTER = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_NEW    = 2'd0;
    localparam logic [1:0] STAT_DUP    = 2'd1;
    localparam logic [1:0] STAT_DENIED = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_DELIVERY_TIME = 2'd1;
    localparam logic [1:0] CFG_MAX_RETRIES   = 2'd2;
    localparam logic [1:0] CFG_UPPER_OFFSET  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        seq_number;
        logic [15:0]       src_addr;
        logic [7:0]        radius;
        logic              from_neighbor;
        logic [4:0]        neighbor_index;
        logic [4:0]        frame_handle;
        logic [1:0]        slot;
        logic [MASK_W-1:0] neighbor_map;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        slot_out;
        logic [1:0]        status;
        logic [MASK_W-1:0] send_mask;
        logic              removed;
        logic              confirm_upper;
        logic [4:0]        upper_handle;
        logic              table_active;
        logic              last;
    } t_out_word;

    // One queued result, before table_active and last are known
    typedef struct packed {
        logic [1:0]        slot_out;
        logic [1:0]        status;
        logic [MASK_W-1:0] send_mask;
        logic              removed;
        logic              confirm_upper;
        logic [4:0]        upper_handle;
    } t_res;

    typedef struct packed {
        logic [7:0]        seq;
        logic [15:0]       src;
        logic [MASK_W-1:0] relayed;
        logic [4:0]        sender_index;
        logic [7:0]        ack_age;
        logic [7:0]        delivery_age;
        logic [2:0]        retries;
        logic [4:0]        handle;
    } t_rec;

    typedef struct packed {
        logic [7:0] ack_timeout;
        logic [7:0] delivery_time;
        logic [2:0] max_retries;
        logic [4:0] upper_handle_offset;
    } t_cfg;

    // One-hot bit for a neighbor index; zero when the index is out of table
    function automatic logic [MASK_W-1:0] nb_bit(input logic [4:0] idx);
        logic [MASK_W-1:0] b;
        b = '0;
        for (int j = 0; j < NEIGHBORS; j++) begin
            b[j] = (idx == 5'(j));
        end
        return b;
    endfunction

endpackage

// File: rtl/core/btt_in_if.sv
// Input channel of the broadcast transaction table: valid, ready, input word.
// Depends on btt_pkg for the word type.
`timescale 1ns / 1ps

interface btt_in_if;
    logic               valid;
    logic               ready;
    btt_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/btt_out_if.sv
// Result channel of the broadcast transaction table: valid, ready, result word.
// Depends on btt_pkg for the word type.
`timescale 1ns / 1ps

interface btt_out_if;
    logic               valid;
    logic               ready;
    btt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/broadcast_transaction_table_unit.sv
// Top level of the broadcast transaction table: record store, sequencer and
// result queue. Depends on btt_pkg, btt_in_if, btt_out_if and btt_rec_unit.
`timescale 1ns / 1ps
// Usage
//   i_in carries one word per request: a new broadcast frame, a jitter
//   timeout for one slot, or a one-second tick. o_out returns the result
//   words of that request in order; the final one has last set. A request
//   that yields nothing (jitter on an empty or out-of-range slot, a tick on
//   an empty table, an unknown function code) returns no word at all.
//   Write configuration through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Throughput
//   One request is in flight at a time; i_in.ready is high only when idle.
//   A new frame walks the table one slot a cycle until it hits a duplicate
//   or reaches the last slot; a tick walks all ENTRIES slots; a jitter timeout
//   reads its own slot only. The result words then go out on o_out, each held
//   until o_out.ready, and the block returns to idle after the last one. The
//   single shared record update unit serves the jitter slot and each slot of
//   the tick walk.
// Reset: clear all record valid bits, the record count and the sequencer;
//   load the configuration reset values.
// Stalls
//   Queued results hold on o_out until o_out.ready; the block takes no new
//   request until the last word of the current one is taken.

module broadcast_transaction_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    btt_in_if.sink      i_in,
    btt_out_if.source   o_out
);

    localparam int IDX_W = btt_pkg::IDX_W;
    localparam int CNT_W = btt_pkg::CNT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_JIT  = 3'd2;
    localparam logic [2:0] ST_TICK = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(btt_pkg::ENTRIES - 1);

    logic [2:0]               r_state, n_state;
    btt_pkg::t_cfg            r_cfg;
    btt_pkg::t_in_word        r_in;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_has_free, n_has_free;
    logic [IDX_W-1:0]         r_free, n_free;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [btt_pkg::ENTRIES-1:0] r_valid, n_valid;
    btt_pkg::t_rec            r_rec [btt_pkg::ENTRIES];
    btt_pkg::t_res            r_q   [btt_pkg::ENTRIES];
    logic [CNT_W-1:0]         r_q_cnt, n_q_cnt;
    logic [IDX_W-1:0]         r_rd_ptr, n_rd_ptr;

    // Record write port and queue push port
    logic                     rec_we;
    logic [IDX_W-1:0]         rec_waddr;
    btt_pkg::t_rec            rec_wdata;
    logic                     q_we;
    btt_pkg::t_res            q_wdata;

    logic                     accept;
    logic                     out_fire;
    logic                     out_last;
    logic [IDX_W-1:0]         rd_addr;
    btt_pkg::t_rec            rd_rec;
    btt_pkg::t_rec            unit_rec;
    btt_pkg::t_res            unit_res;
    logic                     key_match;
    logic                     slot_ok;
    btt_pkg::t_res            q_head;

    assign accept   = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign out_last = (CNT_W'(r_rd_ptr) + CNT_W'(1)) == r_q_cnt;

    // The jitter timeout addresses its own slot; the walks use the counter
    assign rd_addr   = (r_state == ST_JIT) ? IDX_W'(r_in.slot) : r_idx;
    assign rd_rec    = r_rec[rd_addr];
    assign key_match = r_valid[r_idx] && rd_rec.seq == r_in.seq_number
                       && rd_rec.src == r_in.src_addr;
    assign slot_ok   = ({3'b000, r_in.slot} < 5'(btt_pkg::ENTRIES))
                       && r_valid[IDX_W'(r_in.slot)];

    btt_rec_unit u_rec_unit (
        .i_rec  (rd_rec),
        .i_cfg  (r_cfg),
        .i_map  (r_in.neighbor_map),
        .i_tick (r_state == ST_TICK),
        .o_rec  (unit_rec),
        .o_res  (unit_res)
    );

    // Channel outputs
    assign i_in.ready = (r_state == ST_IDLE);
    assign q_head     = r_q[r_rd_ptr];

    always_comb begin
        o_out.valid              = (r_state == ST_EMIT);
        o_out.data.slot_out      = q_head.slot_out;
        o_out.data.status        = q_head.status;
        o_out.data.send_mask     = q_head.send_mask;
        o_out.data.removed       = q_head.removed;
        o_out.data.confirm_upper = q_head.confirm_upper;
        o_out.data.upper_handle  = q_head.upper_handle;
        o_out.data.table_active  = (r_count != '0);
        o_out.data.last          = out_last;
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_has_free = r_has_free;
        n_free     = r_free;
        n_count    = r_count;
        n_valid    = r_valid;
        n_q_cnt    = r_q_cnt;
        n_rd_ptr   = r_rd_ptr;
        rec_we     = 1'b0;
        rec_waddr  = r_idx;
        rec_wdata  = rd_rec;
        q_we       = 1'b0;
        q_wdata    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx      = '0;
                    n_has_free = 1'b0;
                    n_q_cnt    = '0;
                    n_rd_ptr   = '0;
                    unique case (i_in.data.func)
                        btt_pkg::FUNC_NEW:    n_state = ST_SCAN;
                        btt_pkg::FUNC_JITTER: n_state = ST_JIT;
                        btt_pkg::FUNC_TICK:   n_state = ST_TICK;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN: begin
                priority if (key_match) begin
                    // Duplicate: mark the sender as relayed when it is a neighbor in the table
                    if (r_in.from_neighbor && r_in.neighbor_index < 5'(btt_pkg::NEIGHBORS)) begin
                        rec_we            = 1'b1;
                        rec_wdata.relayed = rd_rec.relayed
                                            | btt_pkg::nb_bit(r_in.neighbor_index);
                    end
                    q_we             = 1'b1;
                    q_wdata.slot_out = 2'(r_idx);
                    q_wdata.status   = btt_pkg::STAT_DUP;
                    n_state          = ST_EMIT;
                end else if (r_idx == LAST_IDX) begin
                    q_we = 1'b1;
                    priority if (!r_has_free && r_valid[r_idx]) begin
                        q_wdata.status = btt_pkg::STAT_FULL;
                    end else if (r_in.radius == 8'd0) begin
                        q_wdata.status = btt_pkg::STAT_DENIED;
                    end else begin
                        rec_we                 = 1'b1;
                        rec_waddr              = r_has_free ? r_free : r_idx;
                        rec_wdata.seq          = r_in.seq_number;
                        rec_wdata.src          = r_in.src_addr;
                        rec_wdata.relayed      = '0;
                        rec_wdata.sender_index = r_in.from_neighbor ? r_in.neighbor_index
                                                 : 5'(btt_pkg::NEIGHBORS);
                        rec_wdata.ack_age      = 8'd0;
                        rec_wdata.delivery_age = 8'd0;
                        rec_wdata.retries      = 3'd0;
                        rec_wdata.handle       = r_in.frame_handle;
                        n_valid[rec_waddr]     = 1'b1;
                        n_count                = r_count + CNT_W'(1);
                        q_wdata.slot_out       = 2'(rec_waddr);
                        q_wdata.status         = btt_pkg::STAT_NEW;
                    end
                    n_state = ST_EMIT;
                end else begin
                    // Remember the lowest free slot, advance
                    if (!r_has_free && !r_valid[r_idx]) begin
                        n_has_free = 1'b1;
                        n_free     = r_idx;
                    end
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_JIT: begin
                if (slot_ok) begin
                    rec_we           = 1'b1;
                    rec_waddr        = IDX_W'(r_in.slot);
                    rec_wdata        = unit_rec;
                    q_we             = 1'b1;
                    q_wdata          = unit_res;
                    q_wdata.slot_out = r_in.slot;
                    q_wdata.status   = btt_pkg::STAT_NEW;
                    n_state          = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            ST_TICK: begin
                if (r_valid[r_idx]) begin
                    rec_we           = 1'b1;
                    rec_wdata        = unit_rec;
                    q_we             = 1'b1;
                    q_wdata          = unit_res;
                    q_wdata.slot_out = 2'(r_idx);
                    q_wdata.status   = btt_pkg::STAT_NEW;
                    if (unit_res.removed) begin
                        n_valid[r_idx] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = (r_q_cnt != '0 || r_valid[r_idx]) ? ST_EMIT : ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_EMIT: begin
                if (out_fire) begin
                    if (out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_ptr = r_rd_ptr + IDX_W'(1);
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase

        if (q_we) begin
            n_q_cnt = r_q_cnt + CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_has_free <= 1'b0;
            r_free     <= '0;
            r_count    <= '0;
            r_valid    <= '0;
            r_q_cnt    <= '0;
            r_rd_ptr   <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_has_free <= n_has_free;
            r_free     <= n_free;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_q_cnt    <= n_q_cnt;
            r_rd_ptr   <= n_rd_ptr;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_timeout         <= 8'd3;
            r_cfg.delivery_time       <= 8'd9;
            r_cfg.max_retries         <= 3'd3;
            r_cfg.upper_handle_offset <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btt_pkg::CFG_ACK_TIMEOUT:   r_cfg.ack_timeout         <= i_cfg_data;
                btt_pkg::CFG_DELIVERY_TIME: r_cfg.delivery_time       <= i_cfg_data;
                btt_pkg::CFG_MAX_RETRIES:   r_cfg.max_retries         <= i_cfg_data[2:0];
                btt_pkg::CFG_UPPER_OFFSET:  r_cfg.upper_handle_offset <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Payload registers: latched request, record store, result queue
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in.data;
        end
        if (rec_we) begin
            r_rec[rec_waddr] <= rec_wdata;
        end
        if (q_we) begin
            r_q[r_q_cnt[IDX_W-1:0]] <= q_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("result shown while accepting requests");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("record count differs from valid bits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_state != ST_IDLE) |=> !i_in.ready)
        else $error("request taken while another is in flight");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.data.last) |=> i_in.ready)
        else $error("sequencer did not return to idle after last word");
`endif

endmodule

// File: rtl/core/btt_rec_unit.sv
// Shared record update unit: ages one record on a tick, or relays it on a
// jitter timeout. Depends on btt_pkg for record, config and result types.
`timescale 1ns / 1ps

module btt_rec_unit (
    input  btt_pkg::t_rec                      i_rec,
    input  btt_pkg::t_cfg                      i_cfg,
    input  logic [btt_pkg::MASK_W-1:0]         i_map,
    input  logic                               i_tick,
    output btt_pkg::t_rec                      o_rec,
    output btt_pkg::t_res                      o_res
);

    logic [btt_pkg::MASK_W-1:0] send_mask;
    logic [btt_pkg::MASK_W-1:0] sender_bit;
    logic [7:0]                 ack_inc;
    logic [7:0]                 del_inc;

    assign send_mask  = i_map & ~i_rec.relayed & btt_pkg::NB_MASK;
    assign sender_bit = btt_pkg::nb_bit(i_rec.sender_index);
    assign ack_inc    = i_rec.ack_age + 8'd1;
    assign del_inc    = i_rec.delivery_age + 8'd1;

    always_comb begin
        o_rec = i_rec;
        o_res = '0;
        if (!i_tick) begin
            o_res.send_mask = send_mask;
            if ((send_mask & sender_bit) != '0) begin
                o_rec.relayed = i_rec.relayed | sender_bit;
            end
        end else begin
            o_rec.ack_age      = ack_inc;
            o_rec.delivery_age = del_inc;
            if (ack_inc == i_cfg.ack_timeout) begin
                o_res.send_mask = send_mask;
                if ((send_mask & sender_bit) != '0) begin
                    o_rec.relayed = i_rec.relayed | sender_bit;
                end
                o_rec.ack_age = 8'd0;
                o_rec.retries = i_rec.retries + 3'd1;
            end
            if (del_inc == i_cfg.delivery_time || o_rec.retries == i_cfg.max_retries) begin
                o_res.removed = 1'b1;
                if (i_rec.handle >= i_cfg.upper_handle_offset) begin
                    o_res.confirm_upper = 1'b1;
                    o_res.upper_handle  = i_rec.handle - i_cfg.upper_handle_offset;
                end
            end
        end
    end

endmodule

// File: sim/tb_broadcast_transaction_table_unit.sv
// Testbench for broadcast_transaction_table_unit: a directed pass over the edge cases,
// then random frames, jitter timeouts and ticks under several register settings.
// Depends on btt_pkg, btt_in_if, btt_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_broadcast_transaction_table_unit;

    // The block ignores this function code and returns no word for it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Receiver stall patterns
    localparam logic [1:0] RX_OPEN   = 2'd0;
    localparam logic [1:0] RX_HALF   = 2'd1;
    localparam logic [1:0] RX_SPOTTY = 2'd2;
    localparam logic [1:0] RX_BURSTY = 2'd3;

    // Settling time after the last result: one walk of the table plus margin
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEMS_PER_PHASE = 84;

    // Keeps a copy of the record table and the result words it owes.
    class relay_ledger;
        btt_pkg::t_cfg      regs;
        logic               live [btt_pkg::ENTRIES];
        btt_pkg::t_rec      recs [btt_pkg::ENTRIES];
        int                 held;
        btt_pkg::t_out_word due_results [$];
        int                 mismatches;
        int                 words_in;
        int                 words_checked;
        int                 fills;
        int                 dups;
        int                 rejects;
        int                 removals;
        int                 confirms;

        function new();
            regs.ack_timeout         = 8'd3;
            regs.delivery_time       = 8'd9;
            regs.max_retries         = 3'd3;
            regs.upper_handle_offset = 5'd16;
            for (int i = 0; i < btt_pkg::ENTRIES; i++) begin
                live[i] = 1'b0;
                recs[i] = '0;
            end
            held = 0;
            mismatches = 0;
            words_in = 0;
            words_checked = 0;
            fills = 0;
            dups = 0;
            rejects = 0;
            removals = 0;
            confirms = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                btt_pkg::CFG_ACK_TIMEOUT:   regs.ack_timeout         = val;
                btt_pkg::CFG_DELIVERY_TIME: regs.delivery_time       = val;
                btt_pkg::CFG_MAX_RETRIES:   regs.max_retries         = val[2:0];
                btt_pkg::CFG_UPPER_OFFSET:  regs.upper_handle_offset = val[4:0];
                default: ;
            endcase
        endfunction

        // Send to present neighbors not yet relayed; mark the original sender once hit.
        function logic [btt_pkg::MASK_W-1:0] resend_mask(int s,
                                                          logic [btt_pkg::MASK_W-1:0] map);
            logic [btt_pkg::MASK_W-1:0] m;
            logic [btt_pkg::MASK_W-1:0] b;
            m = map & ~recs[s].relayed & btt_pkg::NB_MASK;
            if (recs[s].sender_index < btt_pkg::NEIGHBORS) begin
                b = btt_pkg::MASK_W'(1) << recs[s].sender_index;
                if ((m & b) != '0)
                    recs[s].relayed = recs[s].relayed | b;
            end
            return m;
        endfunction

        function void note_word(btt_pkg::t_in_word w);
            btt_pkg::t_out_word r;
            btt_pkg::t_out_word batch [$];
            int hit;
            int free_slot;
            hit = -1;
            free_slot = -1;
            r = '0;
            words_in++;
            case (w.func)
                btt_pkg::FUNC_NEW: begin
                    for (int i = 0; i < btt_pkg::ENTRIES; i++) begin
                        if (hit < 0) begin
                            if (live[i] && recs[i].seq == w.seq_number
                                    && recs[i].src == w.src_addr)
                                hit = i;
                            else if (!live[i] && free_slot < 0)
                                free_slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        if (w.from_neighbor && w.neighbor_index < btt_pkg::NEIGHBORS)
                            recs[hit].relayed = recs[hit].relayed
                                | (btt_pkg::MASK_W'(1) << w.neighbor_index);
                        r.slot_out = 2'(hit);
                        r.status   = btt_pkg::STAT_DUP;
                        dups++;
                    end else if (free_slot < 0) begin
                        r.status = btt_pkg::STAT_FULL;
                        rejects++;
                    end else if (w.radius == 8'd0) begin
                        r.status = btt_pkg::STAT_DENIED;
                        rejects++;
                    end else begin
                        live[free_slot]              = 1'b1;
                        recs[free_slot].seq          = w.seq_number;
                        recs[free_slot].src          = w.src_addr;
                        recs[free_slot].relayed      = '0;
                        recs[free_slot].sender_index = w.from_neighbor ? w.neighbor_index
                                                       : 5'(btt_pkg::NEIGHBORS);
                        recs[free_slot].ack_age      = 8'd0;
                        recs[free_slot].delivery_age = 8'd0;
                        recs[free_slot].retries      = 3'd0;
                        recs[free_slot].handle       = w.frame_handle;
                        held++;
                        r.slot_out = 2'(free_slot);
                        r.status   = btt_pkg::STAT_NEW;
                        fills++;
                    end
                    r.table_active = (held != 0);
                    r.last = 1'b1;
                    due_results.push_back(r);
                end
                btt_pkg::FUNC_JITTER: begin
                    if (w.slot < btt_pkg::ENTRIES && live[w.slot]) begin
                        r.slot_out     = w.slot;
                        r.status       = btt_pkg::STAT_NEW;
                        r.send_mask    = resend_mask(int'(w.slot), w.neighbor_map);
                        r.table_active = (held != 0);
                        r.last         = 1'b1;
                        due_results.push_back(r);
                    end
                end
                btt_pkg::FUNC_TICK: begin
                    for (int i = 0; i < btt_pkg::ENTRIES; i++) begin
                        if (live[i]) begin
                            r = '0;
                            r.slot_out = 2'(i);
                            r.status   = btt_pkg::STAT_NEW;
                            recs[i].ack_age      = recs[i].ack_age + 8'd1;
                            recs[i].delivery_age = recs[i].delivery_age + 8'd1;
                            if (recs[i].ack_age == regs.ack_timeout) begin
                                r.send_mask     = resend_mask(i, w.neighbor_map);
                                recs[i].ack_age = 8'd0;
                                recs[i].retries = recs[i].retries + 3'd1;
                            end
                            if (recs[i].delivery_age == regs.delivery_time
                                    || recs[i].retries == regs.max_retries) begin
                                r.removed = 1'b1;
                                if (recs[i].handle >= regs.upper_handle_offset) begin
                                    r.confirm_upper = 1'b1;
                                    r.upper_handle  = recs[i].handle
                                                      - regs.upper_handle_offset;
                                end
                                live[i] = 1'b0;
                                if (held > 0)
                                    held--;
                            end
                            batch.push_back(r);
                        end
                    end
                    // Activity reflects the table after the whole tick
                    for (int k = 0; k < batch.size(); k++) begin
                        batch[k].table_active = (held != 0);
                        batch[k].last = (k == batch.size() - 1);
                        due_results.push_back(batch[k]);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function string show(btt_pkg::t_out_word v);
            return $sformatf("slot=%0d st=%0d mask=%h rm=%b cf=%b uh=%0d act=%b last=%b",
                             v.slot_out, v.status, v.send_mask, v.removed,
                             v.confirm_upper, v.upper_handle, v.table_active, v.last);
        endfunction

        task verify_result(btt_pkg::t_out_word got);
            btt_pkg::t_out_word want;
            string bad;
            bad = "";
            if (due_results.size() == 0) begin
                report({"result word with nothing pending: ", show(got)});
            end else begin
                want = due_results.pop_front();
                words_checked++;
                if (got.slot_out !== want.slot_out)           bad = {bad, " slot_out"};
                if (got.status !== want.status)               bad = {bad, " status"};
                if (got.send_mask !== want.send_mask)         bad = {bad, " send_mask"};
                if (got.removed !== want.removed)             bad = {bad, " removed"};
                if (got.confirm_upper !== want.confirm_upper) bad = {bad, " confirm_upper"};
                if (got.upper_handle !== want.upper_handle)   bad = {bad, " upper_handle"};
                if (got.table_active !== want.table_active)   bad = {bad, " table_active"};
                if (got.last !== want.last)                   bad = {bad, " last"};
                if (bad != "")
                    report({"word ", $sformatf("%0d", words_checked), " bad", bad,
                            " | got ", show(got), " | want ", show(want)});
                if (want.removed)
                    removals++;
                if (want.confirm_upper)
                    confirms++;
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    btt_in_if  in_ch ();
    btt_out_if out_ch ();

    broadcast_transaction_table_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    relay_ledger ledger = new();

    // Key pool: most new frames reuse these so duplicates are common
    logic [7:0]  pool_seq [8];
    logic [15:0] pool_src [8];

    int          burst_left = 0;
    int unsigned rx_cycle = 0;
    logic [1:0]  rx_mode = RX_OPEN;
    int          rx_hold = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case a word never arrives or the input never frees up
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: switch among the stall patterns at random; drive ready on the falling edge.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 48 == 0)
            rx_mode = 2'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ch.ready = 1'b1;
            RX_HALF:   out_ch.ready = rx_cycle[0];
            RX_SPOTTY: out_ch.ready = ($urandom_range(0, 9) > 2);
            default: begin
                if (rx_hold > 0) begin
                    out_ch.ready = 1'b0;
                    rx_hold--;
                end else begin
                    out_ch.ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Check every result word taken at a rising edge against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            ledger.verify_result(out_ch.data);
    end

    // Fill every field at random, with the edge values weighted in.
    function automatic btt_pkg::t_in_word base_word();
        btt_pkg::t_in_word w;
        int pick;
        w.func           = btt_pkg::FUNC_NEW;
        w.seq_number     = 8'($urandom);
        w.src_addr       = 16'($urandom);
        pick = $urandom_range(0, 19);
        w.radius         = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom);
        w.from_neighbor  = 1'($urandom_range(0, 1));
        w.neighbor_index = ($urandom_range(0, 6) == 0) ? 5'(btt_pkg::NEIGHBORS)
                                                       : 5'($urandom_range(0, 15));
        w.frame_handle   = 5'($urandom_range(0, 31));
        w.slot           = 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 19);
        w.neighbor_map   = (pick == 0) ? 16'hffff : (pick == 1) ? 16'h0000 : 16'($urandom);
        return w;
    endfunction

    function automatic btt_pkg::t_in_word bcast_frame(logic [7:0] seq, logic [15:0] src,
                                                      logic [7:0] radius, logic from_nb,
                                                      logic [4:0] nidx, logic [4:0] handle);
        btt_pkg::t_in_word w;
        w = base_word();
        w.func           = btt_pkg::FUNC_NEW;
        w.seq_number     = seq;
        w.src_addr       = src;
        w.radius         = radius;
        w.from_neighbor  = from_nb;
        w.neighbor_index = nidx;
        w.frame_handle   = handle;
        return w;
    endfunction

    function automatic btt_pkg::t_in_word jitter_word(logic [1:0] slot, logic [15:0] map);
        btt_pkg::t_in_word w;
        w = base_word();
        w.func         = btt_pkg::FUNC_JITTER;
        w.slot         = slot;
        w.neighbor_map = map;
        return w;
    endfunction

    function automatic btt_pkg::t_in_word tick_word(logic [15:0] map);
        btt_pkg::t_in_word w;
        w = base_word();
        w.func         = btt_pkg::FUNC_TICK;
        w.neighbor_map = map;
        return w;
    endfunction

    // Mostly well-formed traffic: pooled keys, valid slots, ticks to age records.
    function automatic btt_pkg::t_in_word random_word();
        btt_pkg::t_in_word w;
        int pick;
        int k;
        w = base_word();
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            w.func = btt_pkg::FUNC_NEW;
            if ($urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, 7);
                w.seq_number = pool_seq[k];
                w.src_addr   = pool_src[k];
            end
        end else if (pick < 62) begin
            w.func = btt_pkg::FUNC_JITTER;
            if ($urandom_range(0, 9) == 0)
                w.slot = 2'd3;
        end else if (pick < 96) begin
            w.func = btt_pkg::FUNC_TICK;
        end else begin
            w.func = FUNC_UNUSED;
        end
        return w;
    endfunction

    // Offer one word; idle for a random gap first when the current burst runs out.
    task automatic push_word(input btt_pkg::t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = w;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        ledger.note_word(w);
    endtask

    // Drop valid and hold until every owed result word has been taken.
    task automatic hold_until_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (ledger.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain, then give a word that yields nothing time to finish its walk.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        ledger.set_reg(idx, val);
    endtask

    task automatic apply_regs(input logic [7:0] ack, input logic [7:0] deliv,
                              input logic [2:0] retries, input logic [4:0] offset);
        write_reg(btt_pkg::CFG_ACK_TIMEOUT, ack);
        write_reg(btt_pkg::CFG_DELIVERY_TIME, deliv);
        write_reg(btt_pkg::CFG_MAX_RETRIES, 8'(retries));
        write_reg(btt_pkg::CFG_UPPER_OFFSET, 8'(offset));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        btt_pkg::t_in_word w;
        int done_items;

        // Drive every input to a known value from time zero
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = btt_pkg::CFG_ACK_TIMEOUT;
        i_cfg_data   = 8'd0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        pool_seq[0] = 8'h00;
        pool_src[0] = 16'h0000;
        pool_seq[1] = 8'hff;
        pool_src[1] = 16'hffff;
        for (int k = 2; k < 8; k++) begin
            pool_seq[k] = 8'($urandom);
            pool_src[k] = 16'($urandom);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pass under the reset register values.
        // Items that must yield nothing: tick on an empty table, jitter on an
        // empty slot and on a slot past the table, an unknown function code.
        push_word(tick_word(16'hffff));
        push_word(jitter_word(2'd0, 16'hffff));
        push_word(jitter_word(2'd3, 16'hffff));
        w = base_word();
        w.func = FUNC_UNUSED;
        push_word(w);
        // Radius zero with room left: not permitted
        push_word(bcast_frame(8'h12, 16'h3456, 8'd0, 1'b1, 5'd2, 5'd31));
        // First record: sender is neighbor 0, handle at the top of the range
        push_word(bcast_frame(8'h00, 16'h0000, 8'd255, 1'b1, 5'd0, 5'd31));
        // Duplicates: marks neighbor 5, then local and out-of-table senders change nothing
        push_word(bcast_frame(8'h00, 16'h0000, 8'd1, 1'b1, 5'd5, 5'd0));
        push_word(bcast_frame(8'h00, 16'h0000, 8'd1, 1'b0, 5'd9, 5'd0));
        push_word(bcast_frame(8'h00, 16'h0000, 8'd1, 1'b1, 5'(btt_pkg::NEIGHBORS), 5'd0));
        // Locally originated record, then one whose sender is not in the table
        push_word(bcast_frame(8'hff, 16'hffff, 8'd7, 1'b0, 5'd15, 5'd0));
        push_word(bcast_frame(8'h80, 16'h8000, 8'd1, 1'b1, 5'(btt_pkg::NEIGHBORS), 5'd16));
        // Table full, and full wins over radius zero
        push_word(bcast_frame(8'h01, 16'h0000, 8'd9, 1'b1, 5'd3, 5'd3));
        push_word(bcast_frame(8'h02, 16'h0001, 8'd0, 1'b1, 5'd3, 5'd3));
        // Jitter on each slot: all neighbors present, none, alternate ones
        push_word(jitter_word(2'd0, 16'hffff));
        push_word(jitter_word(2'd1, 16'h0000));
        push_word(jitter_word(2'd2, 16'haaaa));
        // Age the three records through resends until they retire together
        repeat (9) push_word(tick_word(16'h5a5a));

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: apply_regs(8'd1, 8'd4, 3'd7, 5'd0);
                1: apply_regs(8'd255, 8'd255, 3'd7, 5'd10);
                2: apply_regs(8'd0, 8'd0, 3'd0, 5'd31);
                3: apply_regs(8'd2, 8'd6, 3'd2, 5'd20);
                default: apply_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 15)),
                                    3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
            endcase
            done_items = 0;
            while (done_items < ITEMS_PER_PHASE) begin
                w = random_word();
                push_word(w);
                if (w.func != FUNC_UNUSED)
                    done_items++;
                // Now and then let the result side run completely dry
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
            end
        end

        settle();

        $display("Run covered %0d input words over six register settings:", ledger.words_in);
        $display("%0d records filled, %0d duplicates, %0d rejected, %0d result words checked.",
                 ledger.fills, ledger.dups, ledger.rejects, ledger.words_checked);
        $display("Saw %0d retirements and %0d upper-layer confirms.",
                 ledger.removals, ledger.confirms);
        if (ledger.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/btt_pkg.sv
rtl/core/btt_in_if.sv
rtl/core/btt_out_if.sv
rtl/core/btt_rec_unit.sv
rtl/core/broadcast_transaction_table_unit.sv
sim/tb_broadcast_transaction_table_unit.sv
